FILE: hw/rtl/dbc_pkg.sv
// Package for the (16,8) block codec: word types, status codes, the check
// matrix, the syndrome function and the syndrome-to-correction table.
// No dependencies; imported by dec_16_8_block_codec_top.
package dbc_pkg;

   localparam int DataWidth = 8;
   localparam int WordWidth = 16;
   localparam int SynWidth  = 8;
   localparam int NumRows   = 8;
   localparam int NumSyn    = 256;

   // Status codes
   localparam logic [1:0] ST_CLEAN  = 2'd0;
   localparam logic [1:0] ST_SINGLE = 2'd1;
   localparam logic [1:0] ST_DOUBLE = 2'd2;
   localparam logic [1:0] ST_UNCORR = 2'd3;

   // Function codes
   localparam logic FN_ENCODE = 1'b0;
   localparam logic FN_DECODE = 1'b1;

   typedef struct packed {
      logic                 func;
      logic [DataWidth-1:0] data_in;
      logic [WordWidth-1:0] codeword_in;
   } req_word_type;

   typedef struct packed {
      logic [WordWidth-1:0] codeword_out;
      logic [DataWidth-1:0] data_out;
      logic [1:0]           status;
      logic [SynWidth-1:0]  syndrome;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [WordWidth-1:0] flip;
   } fix_entry_type;

   typedef fix_entry_type [NumSyn-1:0] fix_table_type;

   // Row 0 is the leftmost entry, so CheckRows[r] is check row r
   typedef logic [0:NumRows-1][WordWidth-1:0] row_set_type;

   // H = [A | I]; word bit (15 - p) stands for string position p
   localparam row_set_type CheckRows = '{
      16'h5980, 16'hAC40, 16'h5620, 16'h2B10,
      16'h9508, 16'hCA04, 16'h6502, 16'hB201
   };

   // Syndrome of a word; bit 7 is check row 0
   function automatic logic [SynWidth-1:0] syndrome_of(input logic [WordWidth-1:0] word);
      logic [SynWidth-1:0] s;
      s = '0;
      for (int r = 0; r < NumRows; r++) begin
         s[NumRows-1-r] = ^(word & CheckRows[r]);
      end
      return s;
   endfunction

   // Column p of H; bit 7 is row 0
   function automatic logic [SynWidth-1:0] column_of(input int p);
      logic [SynWidth-1:0] c;
      c = '0;
      for (int r = 0; r < NumRows; r++) begin
         c[NumRows-1-r] = CheckRows[r][WordWidth-1-p];
      end
      return c;
   endfunction

   // Correction for every syndrome: singles first, then the first pair i < j
   function automatic fix_table_type build_fix_table();
      fix_table_type t;
      logic [SynWidth-1:0] c;
      for (int s = 0; s < NumSyn; s++) begin
         t[s].status = ST_UNCORR;
         t[s].flip   = '0;
      end
      t[0].status = ST_CLEAN;
      for (int i = 0; i < WordWidth; i++) begin
         c = column_of(i);
         if (t[c].status == ST_UNCORR) begin
            t[c].status = ST_SINGLE;
            t[c].flip   = WordWidth'(1) << (WordWidth-1-i);
         end
      end
      for (int i = 0; i < WordWidth; i++) begin
         for (int j = i + 1; j < WordWidth; j++) begin
            c = column_of(i) ^ column_of(j);
            if (t[c].status == ST_UNCORR) begin
               t[c].status = ST_DOUBLE;
               t[c].flip   = (WordWidth'(1) << (WordWidth-1-i)) |
                             (WordWidth'(1) << (WordWidth-1-j));
            end
         end
      end
      return t;
   endfunction

   localparam fix_table_type FixTable = build_fix_table();

endpackage

FILE: hw/rtl/dec_16_8_block_codec_top.sv
// (16,8) double-error-correcting block codec, top level.
// Depends on dbc_pkg (word types, check matrix, correction table).
//
// Usage:
//   Input channel req_valid / req_stall / req_word carries one word per
//   item: func selects encode (data_in -> 16-bit codeword) or decode
//   (codeword_in -> syndrome, correction, data byte). Result channel
//   rsp_valid / rsp_stall / rsp_word returns one word per item, in order.
//   A word moves when valid is high and stall is low at a rising edge.
//
//   Stages: the input register loads at the accepting edge; the result
//   register loads from it when empty or draining, and rsp_valid shows
//   it. Throughput: one word per cycle while rsp_stall is low; the
//   correction is a single constant-table lookup on the syndrome.
//
//   Reset (synchronous, active high) empties both stages; payload registers
//   are not cleared. When the receiver stalls, the result word holds, the
//   input stage still takes one word if it is empty, and req_stall rises
//   only once both stages are full.
module dec_16_8_block_codec_top
   import dbc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   // Input stage
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;

   // Result stage
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff, out_word_in;

   logic out_advance;
   logic in_advance;

   logic [WordWidth-1:0] check_word;
   logic [SynWidth-1:0]  syn;
   fix_entry_type        fix;
   logic [WordWidth-1:0] fixed_word;

   // Result stage loads when empty or being drained this cycle
   assign out_advance = !out_valid_ff || !rsp_stall;
   // Input stage loads when empty or handing its word on
   assign in_advance  = !in_valid_ff || out_advance;
   assign req_stall   = !in_advance;

   assign in_valid_in  = in_advance ? req_valid : in_valid_ff;
   assign out_valid_in = out_advance ? in_valid_ff : out_valid_ff;

   // Encode runs the data byte with zero checks through the same syndrome tree
   assign check_word = (in_word_ff.func == FN_DECODE) ? in_word_ff.codeword_in
                                                      : {in_word_ff.data_in, 8'h00};
   assign syn        = syndrome_of(check_word);
   assign fix        = FixTable[syn];
   assign fixed_word = in_word_ff.codeword_in ^ fix.flip;

   always_comb begin
      if (in_word_ff.func == FN_DECODE) begin
         out_word_in.codeword_out = fixed_word;
         out_word_in.data_out     = fixed_word[WordWidth-1 -: DataWidth];
         out_word_in.status       = fix.status;
         out_word_in.syndrome     = syn;
      end else begin
         // Append the checks; the decode-only fields stay zero
         out_word_in.codeword_out = {in_word_ff.data_in, syn};
         out_word_in.data_out     = '0;
         out_word_in.status       = ST_CLEAN;
         out_word_in.syndrome     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         in_word_ff <= req_word;
      end
      if (out_advance) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule
